// ----- design/bdq_pkg.sv -----
// Shared opcode, status and width constants for the bounded deque store.
`timescale 1ns / 1ps
package bdq_pkg;

  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;
  localparam int WORD_W   = 32;  // width of value fields on the ports

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_CONTAINS   = 3'd4;
  localparam logic [OP_W-1:0] OP_REMOVE     = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // result flags carried on out_tuser: found, then status
  localparam int OUT_USER_W = 1 + STATUS_W;

endpackage

// ----- design/bounded_deque_bag_store.sv -----
// Bounded double-ended queue of signed words with search and remove.
//
// Input stream: in_tuser carries the opcode (push front, push back, pop front,
// pop back, contains, remove value), in_tdata the 32-bit value. One result
// transfer follows every input transfer, in order, on the out_ stream:
// front value, back value and count in out_tdata, found and status in
// out_tuser.
//
// Entries live in a ring in a single synchronous memory (one read, one write
// port). Pushes, pops and unused opcodes pass from the input transfer through
// S_EXEC, S_RD_F, S_RD_B and S_RD_L to S_OUT, where the result is loaded; the
// next input is taken once the FSM is back in S_IDLE. Contains adds a memory
// scan in S_SEARCH; remove adds the scan plus the read/write-back in S_SHIFT
// that closes the gap. No new input is taken until the previous one is done.
// All of it is paced by the one memory read port.
//
// Reset (rst_n low, synchronous) empties the store; memory contents are not
// cleared and need no sweep. The input is taken while a previous result is
// still waiting; if the receiver stalls, the next item runs through its work
// and then holds until the output register frees up.
module bounded_deque_bag_store #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int OUT_DATA_W = ((2 * bdq_pkg::WORD_W + CW + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [bdq_pkg::WORD_W-1:0]    in_tdata,   // value
  input  logic [bdq_pkg::OP_W-1:0]      in_tuser,   // opcode
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [OUT_DATA_W-1:0]         out_tdata,  // front_value, back_value, count
  output logic [bdq_pkg::OUT_USER_W-1:0] out_tuser  // found, status
);
  import bdq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int SW = CW + 1;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_EXEC   = 8'b0000_0010,
    S_SEARCH = 8'b0000_0100,
    S_SHIFT  = 8'b0000_1000,
    S_RD_F   = 8'b0001_0000,
    S_RD_B   = 8'b0010_0000,
    S_RD_L   = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  // ring position of the k-th entry from the front
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] k);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(k);
    if (s >= SW'(CAPACITY)) s = s - SW'(CAPACITY);
    return s[AW-1:0];
  endfunction

  state_t state_r, state_nxt;

  logic [AW-1:0] fi_r, fi_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] dst_r, dst_nxt;
  logic          pend_r, pend_nxt;
  logic          found_r, found_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;

  logic [OP_W-1:0]              op_r, op_nxt;
  logic signed [DATA_WIDTH-1:0] w_r, w_nxt;
  logic signed [DATA_WIDTH-1:0] front_r, front_nxt;
  logic signed [DATA_WIDTH-1:0] back_r, back_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]       out_data_r, out_data_nxt;
  logic [OUT_USER_W-1:0]       out_user_r, out_user_nxt;

  logic signed [DATA_WIDTH-1:0] mem [CAPACITY];
  logic signed [DATA_WIDTH-1:0] mem_q;
  logic [AW-1:0]                rd_addr;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic signed [DATA_WIDTH-1:0] wr_data;

  logic                         hit;
  logic                         cnt_full, cnt_empty;
  logic [CW-1:0]                last_k;
  logic [AW-1:0]                fi_dec, fi_inc;
  logic signed [WORD_W-1:0]     front_o, back_o;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign cnt_full  = (cnt_r == CW'(CAPACITY));
  assign cnt_empty = (cnt_r == '0);
  assign last_k    = cnt_empty ? '0 : cnt_r - CW'(1);
  assign fi_dec    = (fi_r == '0) ? AW'(CAPACITY - 1) : fi_r - AW'(1);
  assign fi_inc    = (fi_r == AW'(CAPACITY - 1)) ? '0 : fi_r + AW'(1);
  assign hit       = pend_r && (mem_q == w_r);

  assign front_o = cnt_empty ? '0 : WORD_W'(front_r);
  assign back_o  = cnt_empty ? '0 : WORD_W'(back_r);

  // entry memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    mem_q <= mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    fi_nxt        = fi_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    dst_nxt       = dst_r;
    pend_nxt      = pend_r;
    found_nxt     = found_r;
    status_nxt    = status_r;
    op_nxt        = op_r;
    w_nxt         = w_r;
    front_nxt     = front_r;
    back_nxt      = back_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    rd_addr       = fi_r;
    wr_en         = 1'b0;
    wr_addr       = fi_r;
    wr_data       = w_r;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          w_nxt     = DATA_WIDTH'($signed(in_tdata));
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        found_nxt  = 1'b0;
        status_nxt = ST_OK;
        state_nxt  = S_RD_F;
        unique case (op_r) inside
          OP_PUSH_FRONT: begin
            if (cnt_full) begin
              status_nxt = ST_FULL;
            end else begin
              fi_nxt  = fi_dec;
              wr_en   = 1'b1;
              wr_addr = fi_dec;
              cnt_nxt = cnt_r + CW'(1);
            end
          end
          OP_PUSH_BACK: begin
            if (cnt_full) begin
              status_nxt = ST_FULL;
            end else begin
              wr_en   = 1'b1;
              wr_addr = slot_of(fi_r, cnt_r);
              cnt_nxt = cnt_r + CW'(1);
            end
          end
          OP_POP_FRONT: begin
            if (cnt_empty) begin
              status_nxt = ST_EMPTY;
            end else begin
              fi_nxt  = fi_inc;
              cnt_nxt = cnt_r - CW'(1);
            end
          end
          OP_POP_BACK: begin
            if (cnt_empty) status_nxt = ST_EMPTY;
            else cnt_nxt = cnt_r - CW'(1);
          end
          OP_CONTAINS, OP_REMOVE: begin
            k_nxt     = '0;
            pend_nxt  = 1'b0;
            state_nxt = S_SEARCH;
          end
          default: begin
          end
        endcase
      end
      S_SEARCH: begin
        // one read issued per cycle, compare works on the previous read's data
        rd_addr = slot_of(fi_r, k_r);
        if (hit) begin
          found_nxt = 1'b1;
          pend_nxt  = 1'b0;
          // match sits at k_r-1; shifting starts reading at k_r
          state_nxt = (op_r == OP_REMOVE) ? S_SHIFT : S_RD_F;
        end else if (k_r == cnt_r) begin
          status_nxt = ST_NOT_FOUND;
          pend_nxt   = 1'b0;
          state_nxt  = S_RD_F;
        end else begin
          k_nxt    = k_r + CW'(1);
          pend_nxt = 1'b1;
        end
      end
      S_SHIFT: begin
        rd_addr = slot_of(fi_r, k_r);
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = slot_of(fi_r, dst_r);
          wr_data = mem_q;
        end
        if (k_r == cnt_r) begin
          cnt_nxt   = cnt_r - CW'(1);
          pend_nxt  = 1'b0;
          state_nxt = S_RD_F;
        end else begin
          dst_nxt  = k_r - CW'(1);
          k_nxt    = k_r + CW'(1);
          pend_nxt = 1'b1;
        end
      end
      S_RD_F: begin
        rd_addr   = fi_r;
        state_nxt = S_RD_B;
      end
      S_RD_B: begin
        rd_addr   = slot_of(fi_r, last_k);
        front_nxt = mem_q;
        state_nxt = S_RD_L;
      end
      S_RD_L: begin
        back_nxt  = mem_q;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_DATA_W'({cnt_r, back_o, front_o});
          out_user_nxt  = {status_r, found_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fi_r        <= '0;
      cnt_r       <= '0;
      k_r         <= '0;
      dst_r       <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      status_r    <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fi_r        <= fi_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      dst_r       <= dst_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    w_r        <= w_nxt;
    front_r    <= front_nxt;
    back_r     <= back_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

endmodule
